// ----- hw/rtl/tvsu_pkg.sv -----
// ----------------------------------------------------------------------------
// tvsu_pkg
// shared constants and types of the total-variation stencil update block
// ----------------------------------------------------------------------------
package tvsu_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // control bits that travel down the pipeline next to the data
  typedef struct packed {
    logic vld;
    logic flat;
    logic neg;
  } tvsu_tag_t;

endpackage

// ----- hw/rtl/tvsu_nbhd_if.sv -----
// ----------------------------------------------------------------------------
// tvsu_nbhd_if
// valid/ready channel carrying one 3x3 neighborhood of signed samples
// ----------------------------------------------------------------------------
interface tvsu_nbhd_if #(
  parameter int W = tvsu_pkg::SAMPLE_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] center_sample;
  logic signed [W-1:0] left_sample;
  logic signed [W-1:0] right_sample;
  logic signed [W-1:0] up_sample;
  logic signed [W-1:0] down_sample;
  logic signed [W-1:0] up_left_sample;
  logic signed [W-1:0] up_right_sample;
  logic signed [W-1:0] down_left_sample;
  logic signed [W-1:0] down_right_sample;

  modport source (
    output valid, center_sample, left_sample, right_sample, up_sample, down_sample,
           up_left_sample, up_right_sample, down_left_sample, down_right_sample,
    input  ready
  );

  modport sink (
    input  valid, center_sample, left_sample, right_sample, up_sample, down_sample,
           up_left_sample, up_right_sample, down_left_sample, down_right_sample,
    output ready
  );
endinterface

// ----- hw/rtl/tvsu_upd_if.sv -----
// ----------------------------------------------------------------------------
// tvsu_upd_if
// valid/ready channel carrying one updated center sample
// ----------------------------------------------------------------------------
interface tvsu_upd_if #(
  parameter int W = tvsu_pkg::SAMPLE_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] updated_sample;

  modport source (
    output valid, updated_sample,
    input  ready
  );

  modport sink (
    input  valid, updated_sample,
    output ready
  );
endinterface

// ----- hw/rtl/tvsu_div.sv -----
// ----------------------------------------------------------------------------
// tvsu_div
// pipelined restoring divider, one quotient bit per stage, for a quotient
// known to stay below 2^(SAMPLE_BITS+2)
// ----------------------------------------------------------------------------
module tvsu_div #(
  parameter int SAMPLE_BITS = tvsu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  tvsu_pkg::tvsu_tag_t           tag_in,
  input  logic signed [SAMPLE_BITS-1:0] c_in,
  input  logic [2*SAMPLE_BITS:0]        den_in,
  input  logic [3*SAMPLE_BITS+2:0]      mag_in,
  output tvsu_pkg::tvsu_tag_t           tag_out,
  output logic signed [SAMPLE_BITS-1:0] c_out,
  output logic [SAMPLE_BITS+1:0]        quo_out
);
  import tvsu_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int DNW = 2 * S + 1;
  localparam int MW  = 3 * S + 3;
  localparam int QB  = S + 2;

  tvsu_tag_t           tag      [QB];
  logic signed [S-1:0] c_r      [QB];
  logic [DNW-1:0]      den      [QB];
  logic [MW-1:0]       rem      [QB];
  logic [QB-1:0]       quo      [QB];

  tvsu_tag_t           tag_src  [QB];
  logic signed [S-1:0] c_src    [QB];
  logic [DNW-1:0]      den_src  [QB];
  logic [MW-1:0]       rem_src  [QB];
  logic [QB-1:0]       quo_src  [QB];
  logic [MW:0]         diff     [QB];
  logic [MW-1:0]       rem_next [QB];
  logic [QB-1:0]       quo_next [QB];

  always_comb begin
    for (int g = 0; g < QB; g++) begin
      if (g == 0) begin
        tag_src[g] = tag_in;
        c_src[g]   = c_in;
        den_src[g] = den_in;
        rem_src[g] = mag_in;
        quo_src[g] = '0;
      end else begin
        tag_src[g] = tag[g-1];
        c_src[g]   = c_r[g-1];
        den_src[g] = den[g-1];
        rem_src[g] = rem[g-1];
        quo_src[g] = quo[g-1];
      end
      // trial subtract of the divisor aligned to this stage's quotient bit
      diff[g] = {1'b0, rem_src[g]} - ((MW + 1)'(den_src[g]) << (QB - 1 - g));
      if (!diff[g][MW]) begin
        rem_next[g] = diff[g][MW-1:0];
        quo_next[g] = quo_src[g] | (QB'(1) << (QB - 1 - g));
      end else begin
        rem_next[g] = rem_src[g];
        quo_next[g] = quo_src[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < QB; g++) tag[g] <= '0;
    end else if (adv) begin
      for (int g = 0; g < QB; g++) tag[g] <= tag_src[g];
    end
    if (adv) begin
      for (int g = 0; g < QB; g++) begin
        c_r[g] <= c_src[g];
        den[g] <= den_src[g];
        rem[g] <= rem_next[g];
        quo[g] <= quo_next[g];
      end
    end
  end

  assign tag_out = tag[QB-1];
  assign c_out   = c_r[QB-1];
  assign quo_out = quo[QB-1];

endmodule

// ----- hw/rtl/tv_stencil_update_top.sv -----
// ----------------------------------------------------------------------------
// tv_stencil_update_top
// total-variation curvature diffusion update of one center sample from its
// 3x3 neighborhood
// ----------------------------------------------------------------------------
// nbhd carries the nine signed samples of one neighborhood; upd returns the
// updated center sample, one transfer out for every transfer in, in order.
// Gradients, cross term and the exact numerator and denominator are formed
// in five stages, the quotient comes from a divider with one stage per
// quotient bit (SAMPLE_BITS+2 stages), then four stages add the center,
// divide by five through a reciprocal multiply and saturate.
// One neighborhood is taken every cycle unless a result waits, so the
// sustained rate is one item per clock.
// A flat neighborhood (no horizontal or vertical gradient) returns the
// center sample unchanged.
// Synchronous reset empties the pipeline; the result register drives upd.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and nbhd.ready drops in the same cycle; nothing is dropped or
// repeated, and a transfer in is refused only while a result waits.
// ----------------------------------------------------------------------------
module tv_stencil_update_top #(
  parameter int SAMPLE_BITS = tvsu_pkg::SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tvsu_nbhd_if.sink  nbhd,
  tvsu_upd_if.source upd
);
  import tvsu_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int DW  = S + 1;
  localparam int XW  = S + 2;
  localparam int PW  = 2 * S;
  localparam int AW  = 3 * S + 1;
  localparam int EW  = 3 * S + 2;
  localparam int NW  = 3 * S + 4;
  localparam int MW  = 3 * S + 3;
  localparam int QB  = S + 2;
  localparam int SW  = S + 3;
  localparam int N   = S + 2;
  localparam logic [N-1:0] RECIP = N'(((64'd1 << (N + 2)) + 64'd4) / 64'd5);
  localparam logic signed [S:0] MAXV = (S + 1)'(2 ** (S - 1) - 1);
  localparam logic signed [S:0] MINV = (S + 1)'(-(2 ** (S - 1)));

  logic adv;

  // stage 1: differences and pair sums
  tvsu_tag_t            tag1;
  logic signed [DW-1:0] dx1, dy1, su1, sl1;
  logic signed [XW-1:0] cr1;
  logic signed [S-1:0]  c1;

  // stage 2: squares and gradient product
  tvsu_tag_t            tag2;
  logic [PW-1:0]        dxsq2, dysq2;
  logic signed [PW:0]   dxy2;
  logic signed [DW-1:0] su2, sl2;
  logic signed [XW-1:0] cr2;
  logic signed [S-1:0]  c2;

  // stage 3: weighted terms and denominator
  tvsu_tag_t            tag3;
  logic signed [AW-1:0] a3, b3;
  logic signed [EW-1:0] e3;
  logic [2*S:0]         den3;
  logic signed [S-1:0]  c3;

  // stage 4: numerator
  tvsu_tag_t            tag4;
  logic signed [NW-1:0] num4;
  logic signed [NW-1:0] wsum4;
  logic signed [NW-1:0] num_next;
  logic [2*S:0]         den4;
  logic signed [S-1:0]  c4;

  // stage 5: sign and magnitude
  tvsu_tag_t            tag5;
  logic [NW-1:0]        nabs5;
  logic [MW-1:0]        mag5;
  logic [2*S:0]         den5;
  logic signed [S-1:0]  c5;

  // divider output
  tvsu_tag_t            tagq;
  logic signed [S-1:0]  cq;
  logic [QB-1:0]        quoq;

  // stages A to D: center add, magnitude, reciprocal multiply, saturate
  tvsu_tag_t            taga;
  logic signed [SW-1:0] qsa;
  logic signed [SW-1:0] sa;
  logic signed [S-1:0]  ca;

  tvsu_tag_t            tagb;
  logic [SW-1:0]        sabs;
  logic [N-1:0]         smagb;
  logic signed [S-1:0]  cb;

  tvsu_tag_t            tagc;
  logic [2*N-1:0]       prodc;
  logic [S-1:0]         quotc;
  logic signed [S-1:0]  cc;

  logic signed [S:0]    qsd;
  logic signed [S:0]    vald;
  logic signed [S:0]    satd;
  logic                 vldd;
  logic signed [S-1:0]  resd;

  assign adv        = !vldd || upd.ready;
  assign nbhd.ready = adv;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
      tag5 <= '0;
      taga <= '0;
      tagb <= '0;
      tagc <= '0;
      vldd <= 1'b0;
    end else if (adv) begin
      tag1 <= '{vld: nbhd.valid, flat: 1'b0, neg: 1'b0};
      tag2 <= '{vld: tag1.vld, flat: (dx1 == '0) && (dy1 == '0), neg: 1'b0};
      tag3 <= tag2;
      tag4 <= tag3;
      tag5 <= '{vld: tag4.vld, flat: tag4.flat, neg: num4[NW-1]};
      taga <= tagq;
      tagb <= '{vld: taga.vld, flat: taga.flat, neg: sa[SW-1]};
      tagc <= tagb;
      vldd <= tagc.vld;
    end
  end

  always_comb begin
    wsum4    = NW'(a3) + NW'(b3);
    num_next = (wsum4 <<< 1) - NW'(e3);
    nabs5    = num4[NW-1] ? NW'(-num4) : NW'(num4);
    qsa      = $signed({1'b0, quoq});
    sabs     = sa[SW-1] ? SW'(-sa) : SW'(sa);
    prodc    = (2 * N)'(smagb) * (2 * N)'(RECIP);
    qsd      = $signed({1'b0, quotc});
    vald     = tagc.neg ? -qsd : qsd;
    if (vald > MAXV) begin
      satd = MAXV;
    end else if (vald < MINV) begin
      satd = MINV;
    end else begin
      satd = vald;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      dx1   <= DW'(nbhd.right_sample) - DW'(nbhd.left_sample);
      dy1   <= DW'(nbhd.down_sample) - DW'(nbhd.up_sample);
      su1   <= DW'(nbhd.up_sample) + DW'(nbhd.down_sample);
      sl1   <= DW'(nbhd.left_sample) + DW'(nbhd.right_sample);
      cr1   <= XW'(nbhd.down_right_sample) + XW'(nbhd.up_left_sample)
             - XW'(nbhd.up_right_sample) - XW'(nbhd.down_left_sample);
      c1    <= nbhd.center_sample;

      dxsq2 <= PW'(dx1) * PW'(dx1);
      dysq2 <= PW'(dy1) * PW'(dy1);
      dxy2  <= (PW + 1)'(dx1) * (PW + 1)'(dy1);
      su2   <= su1;
      sl2   <= sl1;
      cr2   <= cr1;
      c2    <= c1;

      a3    <= AW'($signed({1'b0, dxsq2})) * AW'(su2);
      b3    <= AW'($signed({1'b0, dysq2})) * AW'(sl2);
      e3    <= EW'(dxy2) * EW'(cr2);
      den3  <= (2 * S + 1)'(dxsq2) + (2 * S + 1)'(dysq2);
      c3    <= c2;

      num4  <= num_next;
      den4  <= den3;
      c4    <= c3;

      mag5  <= nabs5[MW-1:0];
      den5  <= den4;
      c5    <= c4;

      sa    <= SW'(cq) + (tagq.neg ? -qsa : qsa);
      ca    <= cq;

      smagb <= sabs[N-1:0];
      cb    <= ca;

      quotc <= prodc[2*N-1:N+2];
      cc    <= cb;

      resd  <= tagc.flat ? cc : satd[S-1:0];
    end
  end

  tvsu_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag5),
    .c_in    (c5),
    .den_in  (den5),
    .mag_in  (mag5),
    .tag_out (tagq),
    .c_out   (cq),
    .quo_out (quoq)
  );

  assign upd.valid          = vldd;
  assign upd.updated_sample = resd;

endmodule

// ----- hw/rtl/tvsu_chk.sv -----
// ----------------------------------------------------------------------------
// tvsu_chk
// port-level checks of the stencil update block, bound to the top level
// ----------------------------------------------------------------------------
module tvsu_chk #(
  parameter int SAMPLE_BITS = tvsu_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_data
);
  import tvsu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // back-pressure comes only from the receiver
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind tv_stencil_update_top tvsu_chk #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (nbhd.valid),
  .in_ready  (nbhd.ready),
  .out_valid (upd.valid),
  .out_ready (upd.ready),
  .out_data  (upd.updated_sample)
);
